FILE: rtl/vsl3_pkg.sv
`default_nettype none

package vsl3_pkg;

  localparam int AXES        = 3;
  localparam int MAX_STEP_MS = 1000;

  localparam int DATA_W   = 32;
  localparam int CUTOFF_W = 20;
  localparam int AXCNT_W  = 2;
  localparam int CFG_W    = CUTOFF_W;
  localparam int STEP_W   = $clog2(MAX_STEP_MS + 1);
  localparam int TWOPI_W  = 19;
  localparam int P1_W     = STEP_W + CUTOFF_W;
  localparam int NUM_W    = P1_W + TWOPI_W;
  localparam int DIV_W    = NUM_W + 2;
  localparam int ALPHA_W  = 16;
  localparam int DIFF_W   = DATA_W + 1;
  localparam int PROD_W   = DIFF_W + ALPHA_W + 1;
  localparam int CNT_W    = $clog2(ALPHA_W);
  localparam int AXIS_W   = 2;

  localparam logic [TWOPI_W-1:0] TWO_PI_Q16  = TWOPI_W'(411775);
  localparam logic [DIV_W-1:0]   MILLION_Q16 = DIV_W'(64'd65536000000);
  localparam logic [STEP_W-1:0]  STEP_MAX    = STEP_W'(MAX_STEP_MS);
  localparam logic [AXIS_W-1:0]  LAST_AXIS   = AXIS_W'(AXES - 1);

  localparam logic CFG_CUTOFF = 1'b0;
  localparam logic CFG_AXES   = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_RESET  = 1'b1;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_CAPTURE = 4'd1;
  localparam logic [3:0] OP_CLEAR   = 4'd2;
  localparam logic [3:0] OP_LOAD    = 4'd3;
  localparam logic [3:0] OP_MUL_A   = 4'd4;
  localparam logic [3:0] OP_MUL_B   = 4'd5;
  localparam logic [3:0] OP_DEN     = 4'd6;
  localparam logic [3:0] OP_DIV     = 4'd7;
  localparam logic [3:0] OP_BMUL    = 4'd8;
  localparam logic [3:0] OP_BADD    = 4'd9;
  localparam logic [3:0] OP_OUT     = 4'd10;

  typedef struct packed {
    logic                     kind;
    logic [DATA_W-1:0]        stamp_ms;
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
  } out_beat_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [AXIS_W-1:0] axis;
  } ctl_cmd_t;

  typedef struct packed {
    logic kind;
    logic direct;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/vsl3_ctrl.sv
`default_nettype none

module vsl3_ctrl
  import vsl3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_MULB   = 3'd2;
  localparam logic [2:0] ST_DEN    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_BMUL   = 3'd5;
  localparam logic [2:0] ST_BADD   = 3'd6;
  localparam logic [2:0] ST_WOUT   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    cmd.op    = OP_NONE;
    cmd.axis  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (stat.kind == KIND_RESET) begin
          cmd.op    = OP_CLEAR;
          state_nxt = ST_IDLE;
        end else if (stat.direct) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_WOUT;
        end else begin
          cmd.op    = OP_MUL_A;
          state_nxt = ST_MULB;
        end
      end
      ST_MULB: begin
        cmd.op    = OP_MUL_B;
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        cmd.op    = OP_DEN;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(ALPHA_W - 1)) begin
          axis_nxt  = '0;
          state_nxt = ST_BMUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_BMUL: begin
        cmd.op    = OP_BMUL;
        state_nxt = ST_BADD;
      end
      ST_BADD: begin
        cmd.op = OP_BADD;
        if (axis_r == LAST_AXIS) begin
          state_nxt = ST_WOUT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_BMUL;
        end
      end
      ST_WOUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vsl3_dp.sv
`default_nettype none

module vsl3_dp
  import vsl3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire in_beat_t         in_data,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output out_beat_t             out_data,
  input  wire ctl_cmd_t         cmd,
  output dp_stat_t              stat
);

  logic [CUTOFF_W-1:0] cutoff_r, cutoff_nxt;
  logic [AXCNT_W-1:0]  axcnt_r, axcnt_nxt;
  in_beat_t            in_r, in_nxt;
  logic [DATA_W-1:0]   filt_r [AXES];
  logic [DATA_W-1:0]   filt_nxt [AXES];
  logic [DATA_W-1:0]   prev_r, prev_nxt;
  logic                primed_r, primed_nxt;
  logic [P1_W-1:0]     p1_r, p1_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [DIV_W-1:0]    den_r, den_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [ALPHA_W-1:0]  q_r, q_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_r, out_nxt;

  logic [AXCNT_W-1:0]  n_act;
  logic [DATA_W-1:0]   dt;
  logic [STEP_W-1:0]   dt_c;
  logic [DIV_W-1:0]    rem_sh;
  logic [DATA_W-1:0]   x_sel;
  logic [DATA_W-1:0]   y_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_bias;
  logic                sel_active;

  assign n_act = (axcnt_r == '0) ? AXCNT_W'(1) : axcnt_r;

  assign dt = in_r.stamp_ms - prev_r;
  always_comb begin
    priority if (dt == '0) begin
      dt_c = STEP_W'(1);
    end else if (dt > DATA_W'(MAX_STEP_MS)) begin
      dt_c = STEP_MAX;
    end else begin
      dt_c = dt[STEP_W-1:0];
    end
  end

  assign rem_sh = {rem_r[DIV_W-2:0], 1'b0};

  always_comb begin
    unique case (cmd.axis)
      2'd0:    begin x_sel = in_r.in_x; y_sel = filt_r[0]; end
      2'd1:    begin x_sel = in_r.in_y; y_sel = filt_r[1]; end
      2'd2:    begin x_sel = in_r.in_z; y_sel = filt_r[2]; end
      default: begin x_sel = '0;        y_sel = '0;        end
    endcase
  end

  assign sel_active = (cmd.axis < n_act);
  assign diff       = $signed({x_sel[DATA_W-1], x_sel}) - $signed({y_sel[DATA_W-1], y_sel});
  assign prod_bias  = prod_r + PROD_W'(32768);

  always_comb begin
    cutoff_nxt    = cutoff_r;
    axcnt_nxt     = axcnt_r;
    in_nxt        = in_r;
    filt_nxt      = filt_r;
    prev_nxt      = prev_r;
    primed_nxt    = primed_r;
    p1_nxt        = p1_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CUTOFF: cutoff_nxt = cfg_wdata;
        CFG_AXES:   axcnt_nxt  = cfg_wdata[AXCNT_W-1:0];
        default:    cutoff_nxt = cutoff_r;
      endcase
    end

    unique case (cmd.op)
      OP_CAPTURE: in_nxt = in_data;
      OP_CLEAR: begin
        for (int i = 0; i < AXES; i++) begin
          filt_nxt[i] = '0;
        end
        prev_nxt   = '0;
        primed_nxt = 1'b0;
      end
      OP_LOAD: begin
        filt_nxt[0] = in_r.in_x;
        filt_nxt[1] = (n_act > AXCNT_W'(1)) ? in_r.in_y : '0;
        filt_nxt[2] = (n_act > AXCNT_W'(2)) ? in_r.in_z : '0;
        prev_nxt    = in_r.stamp_ms;
        primed_nxt  = 1'b1;
      end
      OP_MUL_A: begin
        p1_nxt   = P1_W'(dt_c) * P1_W'(cutoff_r);
        prev_nxt = in_r.stamp_ms;
      end
      OP_MUL_B: num_nxt = NUM_W'(p1_r) * NUM_W'(TWO_PI_Q16);
      OP_DEN: begin
        den_nxt = MILLION_Q16 + DIV_W'(num_r);
        rem_nxt = DIV_W'(num_r);
        q_nxt   = '0;
      end
      OP_DIV: begin
        if (rem_sh >= den_r) begin
          rem_nxt = rem_sh - den_r;
          q_nxt   = {q_r[ALPHA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_r[ALPHA_W-2:0], 1'b0};
        end
      end
      OP_BMUL: prod_nxt = diff * $signed({1'b0, q_r});
      OP_BADD: begin
        unique case (cmd.axis)
          2'd0:    filt_nxt[0] = y_sel + prod_bias[DATA_W+15:16];
          2'd1:    filt_nxt[1] = sel_active ? y_sel + prod_bias[DATA_W+15:16] : '0;
          2'd2:    filt_nxt[2] = sel_active ? y_sel + prod_bias[DATA_W+15:16] : '0;
          default: filt_nxt[0] = filt_r[0];
        endcase
      end
      OP_OUT: begin
        out_nxt.out_x = filt_r[0];
        out_nxt.out_y = filt_r[1];
        out_nxt.out_z = filt_r[2];
        out_valid_nxt = 1'b1;
      end
      default: in_nxt = in_r;
    endcase
  end

  assign stat.kind     = in_r.kind;
  assign stat.direct   = !primed_r || (cutoff_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= '0;
      axcnt_r     <= AXCNT_W'(3);
      for (int i = 0; i < AXES; i++) begin
        filt_r[i] <= '0;
      end
      prev_r      <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cutoff_r    <= cutoff_nxt;
      axcnt_r     <= axcnt_nxt;
      filt_r      <= filt_nxt;
      prev_r      <= prev_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    p1_r   <= p1_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/variable_step_lowpass_3axis_core.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_beat_t: kind, stamp_ms, in_x, in_y, in_z
// out_      output     out_valid / out_stall out_beat_t: out_x, out_y, out_z
// cfg_      input      cfg_we               cfg_index selects cutoff_mhz or the active axis count
//
// A sample beat passes through the multiply and denominator steps, the 16-step restoring
// division for the smoothing factor and one shared multiplier that updates the three axes in
// turn; the input takes no new beat until its result is in the output register. A pass-through
// sample is loaded into the filter state and then the output register; a reset beat clears the
// filter state and frees the input. Reset is synchronous, clears the filter state, the cutoff
// and the output valid flag, and sets the axis count to three. A stalled result holds in the
// output register while the next beat is accepted; the next result waits until it is free.

module variable_step_lowpass_3axis_core
  import vsl3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_beat_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_beat_t             out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  vsl3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vsl3_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
